>>> design/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types and constants for the perspective point projector.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int COEF_FRAC_BITS = 14;
  localparam int DIV_BITS = 64;

  // configuration register indexes
  localparam logic [2:0] REG_SX_COEFS = 3'd0;
  localparam logic [2:0] REG_DEPTH_COEFS = 3'd1;
  localparam logic [2:0] REG_SY_COEFS = 3'd2;
  localparam logic [2:0] REG_CAM_X = 3'd3;
  localparam logic [2:0] REG_CAM_Y = 3'd4;
  localparam logic [2:0] REG_CAM_Z = 3'd5;
  localparam logic [2:0] REG_FOCUS = 3'd6;
  localparam logic [2:0] REG_CENTER = 3'd7;

  localparam logic [30:0] FOCUS_RESET = 31'd65536;

  // side data carried along the divider stages
  typedef struct packed {
    logic        behind;
    logic        last;
    logic [31:0] z;
    logic        zero_div;
    logic        neg_x;
    logic        neg_y;
    logic        nz_x;
    logic        nz_y;
    logic [15:0] cx;
    logic [15:0] cy;
  } side_t;

endpackage

>>> design/ppp_div.sv
// ----------------------------------------------------------------------------
// ppp_div
// Pipelined restoring divider, unsigned, one quotient bit per stage.
// Two dividends share one divisor; a stall freezes every stage.
// ----------------------------------------------------------------------------
module ppp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [63:0]                num_a,
  input  logic [63:0]                num_b,
  input  logic [32:0]                den,
  input  ppp_pkg::side_t             side_in,
  output logic                       out_valid,
  output logic [63:0]                quo_a,
  output logic [63:0]                quo_b,
  output ppp_pkg::side_t             side_out
);

  localparam int N = ppp_pkg::DIV_BITS;

  logic [N:0]      vld;
  logic [63:0]     qa [N+1];
  logic [63:0]     qb [N+1];
  logic [33:0]     ra [N+1];
  logic [33:0]     rb [N+1];
  logic [32:0]     dv [N+1];
  ppp_pkg::side_t  sd [N+1];

  always_comb begin
    vld[0] = in_valid;
    qa[0] = num_a;
    qb[0] = num_b;
    ra[0] = '0;
    rb[0] = '0;
    dv[0] = den;
    sd[0] = side_in;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [33:0] sa, sb;
    logic [34:0] ta, tb;
    always_comb begin
      sa = {ra[i][32:0], qa[i][63]};
      sb = {rb[i][32:0], qb[i][63]};
      ta = {1'b0, sa} - {2'b00, dv[i]};
      tb = {1'b0, sb} - {2'b00, dv[i]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
      if (adv) begin
        ra[i+1] <= ta[34] ? sa : ta[33:0];
        rb[i+1] <= tb[34] ? sb : tb[33:0];
        qa[i+1] <= {qa[i][62:0], ~ta[34]};
        qb[i+1] <= {qb[i][62:0], ~tb[34]};
        dv[i+1] <= dv[i];
        sd[i+1] <= sd[i];
      end
    end
  end

  assign out_valid = vld[N];
  assign quo_a = qa[N];
  assign quo_b = qb[N];
  assign side_out = sd[N];

endmodule

>>> design/perspective_point_projector.sv
// ----------------------------------------------------------------------------
// perspective_point_projector
// Camera offset, 3x3 view matrix, then perspective divide and screen offset.
// ----------------------------------------------------------------------------
// pipeline from accepted point to result word: 4 front stages, 64 divider
// stages, fix-up stage, output register.
// throughput: one point per cycle; a stall on the output halts the whole
// pipeline. rst clears all valid bits and returns the configuration
// registers to their reset values.
module perspective_point_projector #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic               last_point,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y,
  output logic signed [31:0] pass_z,
  output logic               behind_camera,
  output logic               last_out
);

  logic [47:0] sx_coefs, d_coefs, sy_coefs;
  logic [31:0] cam_x, cam_y, cam_z, center;
  logic [30:0] focus;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sx_coefs <= '0;
      d_coefs <= '0;
      sy_coefs <= '0;
      cam_x <= '0;
      cam_y <= '0;
      cam_z <= '0;
      focus <= ppp_pkg::FOCUS_RESET;
      center <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ppp_pkg::REG_SX_COEFS:    sx_coefs <= cfg_data;
        ppp_pkg::REG_DEPTH_COEFS: d_coefs <= cfg_data;
        ppp_pkg::REG_SY_COEFS:    sy_coefs <= cfg_data;
        ppp_pkg::REG_CAM_X:       cam_x <= cfg_data[31:0];
        ppp_pkg::REG_CAM_Y:       cam_y <= cfg_data[31:0];
        ppp_pkg::REG_CAM_Z:       cam_z <= cfg_data[31:0];
        ppp_pkg::REG_FOCUS:       focus <= cfg_data[30:0];
        ppp_pkg::REG_CENTER:      center <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // one global advance: whole pipeline holds while a valid output is stalled
  logic adv;
  assign adv = ~(out_valid & out_stall);
  assign in_stall = ~adv;

  // stage 1: camera offsets
  logic        v1;
  logic signed [32:0] dx, dy, dz;
  logic [31:0] z1;
  logic        l1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
    if (adv) begin
      dx <= 33'(point_x) - 33'(signed'(cam_x));
      dy <= 33'(point_y) - 33'(signed'(cam_y));
      dz <= 33'(point_z) - 33'(signed'(cam_z));
      z1 <= point_z;
      l1 <= last_point;
    end
  end

  // stage 2: nine products
  logic v2;
  logic signed [48:0] p [9];
  logic [31:0] z2;
  logic l2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      p[0] <= signed'(sx_coefs[15:0]) * dx;
      p[1] <= signed'(sx_coefs[31:16]) * dy;
      p[2] <= signed'(sx_coefs[47:32]) * dz;
      p[3] <= signed'(d_coefs[15:0]) * dx;
      p[4] <= signed'(d_coefs[31:16]) * dy;
      p[5] <= signed'(d_coefs[47:32]) * dz;
      p[6] <= signed'(sy_coefs[15:0]) * dx;
      p[7] <= signed'(sy_coefs[31:16]) * dy;
      p[8] <= signed'(sy_coefs[47:32]) * dz;
      z2 <= z1;
      l2 <= l1;
    end
  end

  // stage 3: sums, shift, saturate
  logic signed [50:0] sum_x, sum_d, sum_y;
  logic signed [36:0] sh_x, sh_d, sh_y;
  logic signed [31:0] tx, td, ty;

  function automatic logic signed [31:0] sat37(input logic signed [36:0] v);
    if (v > 37'sd2147483647) return 32'sh7fffffff;
    if (v < -37'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_comb begin
    sum_x = 51'(p[0]) + 51'(p[1]) + 51'(p[2]);
    sum_d = 51'(p[3]) + 51'(p[4]) + 51'(p[5]);
    sum_y = 51'(p[6]) + 51'(p[7]) + 51'(p[8]);
    sh_x = 37'(sum_x >>> ppp_pkg::COEF_FRAC_BITS);
    sh_d = 37'(sum_d >>> ppp_pkg::COEF_FRAC_BITS);
    sh_y = 37'(sum_y >>> ppp_pkg::COEF_FRAC_BITS);
    tx = sat37(sh_x);
    td = sat37(sh_d);
    ty = sat37(sh_y);
  end

  logic v3s;
  logic signed [31:0] tx3, td3, ty3;
  logic behind3, l3;
  logic [31:0] z3;
  always_ff @(posedge clk) begin
    if (rst) v3s <= 1'b0;
    else if (adv) v3s <= v2;
    if (adv) begin
      tx3 <= tx;
      td3 <= td;
      ty3 <= ty;
      behind3 <= sum_d[50];
      l3 <= l2;
      z3 <= z2;
    end
  end

  // stage 4: multiply by focus
  logic v3;
  logic signed [63:0] mx, my;
  logic [32:0] den3;
  ppp_pkg::side_t s3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v3s;
    if (adv) begin
      mx <= tx3 * signed'({1'b0, focus});
      my <= ty3 * signed'({1'b0, focus});
      // depth is non-negative whenever it is used
      den3 <= {1'b0, td3} + {2'b00, focus};
      s3.behind <= behind3;
      s3.last <= l3;
      s3.z <= z3;
      s3.zero_div <= 1'b0;
      s3.neg_x <= tx3[31];
      s3.neg_y <= ty3[31];
      s3.nz_x <= tx3 != '0;
      s3.nz_y <= ty3 != '0;
      s3.cx <= center[15:0];
      s3.cy <= center[31:16];
    end
  end

  // magnitudes into the divider
  ppp_pkg::side_t s3d;
  logic [63:0] ax, ay;
  always_comb begin
    s3d = s3;
    s3d.zero_div = den3 == '0;
    ax = mx[63] ? 64'(-mx) : 64'(mx);
    ay = my[63] ? 64'(-my) : 64'(my);
  end

  logic dvo;
  logic [63:0] qx, qy;
  ppp_pkg::side_t sdo;

  ppp_div u_div (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(v3),
    .num_a(ax), .num_b(ay), .den(den3), .side_in(s3d),
    .out_valid(dvo), .quo_a(qx), .quo_b(qy), .side_out(sdo)
  );

  // back stage 1: sign and zero-divisor handling, clamp far beyond any centre
  function automatic logic signed [47:0] fix_q(input logic [63:0] q, input logic neg,
                                               input logic nz, input logic zd);
    logic signed [47:0] m;
    m = (q > 64'h0000_4000_0000_0000) ? 48'sh4000_0000_0000 : signed'(48'(q));
    if (zd) return nz ? (neg ? -48'sd2147483648 : 48'sd2147483647) : 48'sd0;
    return neg ? -m : m;
  endfunction

  logic v4;
  logic signed [47:0] fx, fy;
  ppp_pkg::side_t s4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= dvo;
    if (adv) begin
      fx <= fix_q(qx, sdo.neg_x, sdo.nz_x, sdo.zero_div);
      fy <= fix_q(qy, sdo.neg_y, sdo.nz_y, sdo.zero_div);
      s4 <= sdo;
    end
  end

  // back stage 2: add centre, saturate, output register
  logic signed [47:0] ox, oy;
  always_comb begin
    ox = fx + signed'(48'(s4.cx) << COORD_FRAC_BITS);
    oy = fy + signed'(48'(s4.cy) << COORD_FRAC_BITS);
  end

  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    if (v > 48'sd2147483647) return 32'sh7fffffff;
    if (v < -48'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= v4;
    if (adv) begin
      screen_x <= s4.behind ? '0 : sat48(ox);
      screen_y <= s4.behind ? '0 : sat48(oy);
      pass_z <= s4.z;
      behind_camera <= s4.behind;
      last_out <= s4.last;
    end
  end

endmodule

>>> tb/sv/ppp_checker.sv
// ----------------------------------------------------------------------------
// ppp_checker
// Watches the config, point and result channels of the perspective point
// projector, predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module ppp_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic               last_point,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] screen_x,
  input  logic signed [31:0] screen_y,
  input  logic signed [31:0] pass_z,
  input  logic               behind_camera,
  input  logic               last_out,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] z;
    logic               behind;
    logic               last;
  } proj_t;

  logic [47:0] m_sx, m_depth, m_sy;
  logic signed [31:0] cam_x, cam_y, cam_z;
  logic [30:0] focus;
  logic [31:0] center;
  proj_t expected_q[$];

  assign pending = expected_q.size();

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor shift: >>> on signed longint rounds toward minus infinity
  function automatic longint dot3(logic [47:0] c, longint dx, longint dy, longint dz);
    longint c0, c1, c2;
    c0 = longint'($signed(c[15:0]));
    c1 = longint'($signed(c[31:16]));
    c2 = longint'($signed(c[47:32]));
    return c0 * dx + c1 * dy + c2 * dz;
  endfunction

  function automatic logic [31:0] scale_term(longint t, longint f, longint d,
                                             logic [15:0] px);
    longint s;
    if (d == 0) s = (t > 0) ? 64'sd2147483647 : ((t < 0) ? -64'sd2147483648 : 0);
    else s = (t * f) / d;
    return 32'(clamp32(s + (longint'(px) << 16)));
  endfunction

  function automatic proj_t project(logic signed [31:0] x, logic signed [31:0] y,
                                    logic signed [31:0] z, logic lst);
    proj_t r;
    longint dx, dy, dz, ds, tx, ty, dep, f;
    dx = longint'(x) - longint'(cam_x);
    dy = longint'(y) - longint'(cam_y);
    dz = longint'(z) - longint'(cam_z);
    ds = dot3(m_depth, dx, dy, dz);
    r = '0;
    r.z = z;
    r.last = lst;
    if (ds < 0) begin
      r.behind = 1'b1;
    end else begin
      tx = clamp32(dot3(m_sx, dx, dy, dz) >>> ppp_pkg::COEF_FRAC_BITS);
      ty = clamp32(dot3(m_sy, dx, dy, dz) >>> ppp_pkg::COEF_FRAC_BITS);
      dep = clamp32(ds >>> ppp_pkg::COEF_FRAC_BITS);
      f = longint'(focus);
      r.sx = scale_term(tx, f, dep + f, center[15:0]);
      r.sy = scale_term(ty, f, dep + f, center[31:16]);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    proj_t e;
    if (rst) begin
      m_sx <= '0; m_depth <= '0; m_sy <= '0;
      cam_x <= '0; cam_y <= '0; cam_z <= '0;
      focus <= ppp_pkg::FOCUS_RESET;
      center <= '0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ppp_pkg::REG_SX_COEFS:    m_sx <= cfg_data;
          ppp_pkg::REG_DEPTH_COEFS: m_depth <= cfg_data;
          ppp_pkg::REG_SY_COEFS:    m_sy <= cfg_data;
          ppp_pkg::REG_CAM_X:       cam_x <= cfg_data[31:0];
          ppp_pkg::REG_CAM_Y:       cam_y <= cfg_data[31:0];
          ppp_pkg::REG_CAM_Z:       cam_z <= cfg_data[31:0];
          ppp_pkg::REG_FOCUS:       focus <= cfg_data[30:0];
          ppp_pkg::REG_CENTER:      center <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_q.push_back(project(point_x, point_y, point_z, last_point));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (screen_x !== e.sx || screen_y !== e.sy || pass_z !== e.z ||
              behind_camera !== e.behind || last_out !== e.last) begin
            if (screen_x !== e.sx) $error("screen_x exp %h got %h", e.sx, screen_x);
            if (screen_y !== e.sy) $error("screen_y exp %h got %h", e.sy, screen_y);
            if (pass_z !== e.z) $error("pass_z exp %h got %h", e.z, pass_z);
            if (behind_camera !== e.behind)
              $error("behind_camera exp %b got %b", e.behind, behind_camera);
            if (last_out !== e.last) $error("last_out exp %b got %b", e.last, last_out);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives config phases and point streams into the projector with random
// idling on both sides; the checker predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LATENCY = 70;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic last_point = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] screen_x, screen_y, pass_z;
  logic behind_camera, last_out;
  int fail_count, pending;
  int idle_pct = 30;
  int quiet;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  perspective_point_projector dut (.*);
  ppp_checker chk (.*);

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < idle_pct);
  end

  // watchdog: cycles with no word moving on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || rst)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("perspective_point_projector test failed");
      $finish;
    end
  end

  // leaves valid high so that writes can follow back to back
  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic lst);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x <= x; point_y <= y; point_z <= z; last_point <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'($signed($urandom_range(400)) - 200) <<< 16;
    endcase
  endfunction

  function automatic logic [15:0] rnd_coef();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  task automatic random_config(bit extreme);
    logic [47:0] d;
    for (int r = 0; r < 8; r++) begin
      if (r < 3) d = {rnd_coef(), rnd_coef(), rnd_coef()};
      else if (r == ppp_pkg::REG_FOCUS)
        d = extreme ? {17'd0, $urandom_range(1) ? 31'h7fffffff : 31'd0}
                    : {17'd0, 31'($urandom_range(1 << 22))};
      else if (r == ppp_pkg::REG_CENTER) d = extreme ? 48'hffff_ffff : {16'd0, 32'($urandom)};
      else d = extreme ? {16'd0, rnd_coord()} : {16'd0, 32'($urandom_range(20) << 16)};
      write_reg(3'(r), d);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset config, then identity view with depth along y
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_point(32'h0, 32'h0, 32'h0, 1'b1);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    in_valid <= 1'b0;
    drain();
    write_reg(ppp_pkg::REG_SX_COEFS, {16'd0, 16'd0, 16'h4000});
    write_reg(ppp_pkg::REG_DEPTH_COEFS, {16'd0, 16'h4000, 16'd0});
    write_reg(ppp_pkg::REG_SY_COEFS, {16'h4000, 16'd0, 16'd0});
    write_reg(ppp_pkg::REG_FOCUS, 48'd0);
    write_reg(ppp_pkg::REG_CENTER, {16'd0, 16'd240, 16'd320});
    write_reg(ppp_pkg::REG_CAM_X, 48'd0);
    cfg_valid <= 1'b0;
    // zero divisor with positive, negative and zero terms
    send_point(32'h0001_0000, 32'h0, 32'hffff_0000, 1'b0);
    send_point(32'hffff_0000, 32'h0, 32'h0001_0000, 1'b0);
    send_point(32'h0, 32'h0, 32'h0, 1'b0);
    // behind camera, then just in front of it with extreme x and z
    send_point(32'h0005_0000, 32'hffff_ffff, 32'h0003_0000, 1'b1);
    send_point(32'h7fff_ffff, 32'h0000_0001, 32'h8000_0000, 1'b0);
    in_valid <= 1'b0;
    drain();
    write_reg(ppp_pkg::REG_FOCUS, 48'h7fff_ffff);
    write_reg(ppp_pkg::REG_CENTER, 48'hffff_ffff);
    write_reg(ppp_pkg::REG_CAM_Y, 48'h8000_0000);
    write_reg(ppp_pkg::REG_CAM_Z, 48'h7fff_ffff);
    write_reg(ppp_pkg::REG_SX_COEFS, {16'h8000, 16'h7fff, 16'h8000});
    write_reg(ppp_pkg::REG_SY_COEFS, {16'h7fff, 16'h8000, 16'h7fff});
    write_reg(ppp_pkg::REG_DEPTH_COEFS, {16'h7fff, 16'h7fff, 16'h7fff});
    cfg_valid <= 1'b0;
    for (int i = 0; i < 8; i++)
      send_point(rnd_coord(), rnd_coord(), rnd_coord(), i[0]);
    in_valid <= 1'b0;
    drain();

    // random phases with new settings, one phase without idling
    for (int ph = 0; ph < 10; ph++) begin
      random_config(ph % 3 == 0);
      idle_pct = (ph == 4) ? 0 : 30;
      n = 150;
      for (int i = 0; i < n; i++) begin
        send_point(rnd_coord(), rnd_coord(), rnd_coord(), ($urandom_range(7) == 0));
        // sender holds off until everything has come back
        if (i == 75 && ph == 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      in_valid <= 1'b0;
      drain();
    end

    if (fail_count == 0)
      $display("perspective_point_projector test passed");
    else
      $display("perspective_point_projector test failed");
    $finish;
  end
endmodule
